// ===== rtl/core/ifmt_pkg.sv =====
// Shared types and constants for the integer-to-ASCII formatter.
// Holds the mode codes, character selects and the controller/datapath
// command and status structs. No dependencies.
package ifmt_pkg;

   localparam int VALUE_W   = 64;
   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int DIGITS    = 20;
   localparam int BCD_W     = DIGITS * DIGIT_W;
   localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
   localparam int CNT_W     = 5;
   localparam int STEP_W    = 6;

   localparam logic [MODE_W-1:0] MODE_HEX      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_X,
      SEL_MINUS,
      SEL_DIGIT
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         step;
      logic         shift;
      logic         out_load;
      logic         out_last;
      char_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic is_hex;
      logic is_neg;
      logic top_zero;
      logic cnt_one;
      logic step_last;
   } status_type;

   // Maps one digit to its ASCII glyph from "0123456789ABCDEF".
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         glyph = ASCII_ZERO + ext;
      end else begin
         glyph = ASCII_UPPER_A + ext - 8'd10;
      end
   endfunction

endpackage

// ===== rtl/core/ifmt_datapath.sv =====
// Datapath of the integer-to-ASCII formatter: binary and digit registers,
// shift-add-3 decimal conversion, digit counter and output payload register.
// Depends on ifmt_pkg.
module ifmt_datapath (
   input  logic                           clock,
   input  logic [ifmt_pkg::VALUE_W-1:0]   req_value,
   input  logic [ifmt_pkg::MODE_W-1:0]    req_mode,
   input  ifmt_pkg::cmd_type              cmd,
   output ifmt_pkg::status_type           status,
   output logic [ifmt_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last
);
   import ifmt_pkg::*;

   logic [VALUE_W-1:0] bin_ff;
   logic [BCD_W-1:0]   bcd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               hex_ff;
   logic               neg_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;

   logic [BCD_W-1:0]   adj;
   logic [VALUE_W-1:0] mag;
   logic               hex_in;
   logic               neg_in;
   logic [DIGIT_W-1:0] top_digit;
   logic [CHAR_W-1:0]  char_in;

   assign hex_in    = (req_mode == MODE_HEX);
   assign neg_in    = (req_mode == MODE_SIGNED) && req_value[VALUE_W-1];
   assign mag       = neg_in ? (VALUE_W'(0) - req_value) : req_value;
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

   // Every decimal digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      unique case (cmd.out_sel)
         SEL_ZERO:  char_in = ASCII_ZERO;
         SEL_X:     char_in = ASCII_X;
         SEL_MINUS: char_in = ASCII_MINUS;
         SEL_DIGIT: char_in = glyph(top_digit);
         default:   char_in = ASCII_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff  <= mag;
         step_ff <= '0;
         hex_ff  <= hex_in;
         neg_ff  <= neg_in;
         if (hex_in) begin
            // Hex digits are the value's nibbles, aligned to the top.
            bcd_ff <= {req_value, {(BCD_W-VALUE_W){1'b0}}};
            cnt_ff <= CNT_W'(HEX_DIGITS);
         end else begin
            bcd_ff <= '0;
            cnt_ff <= CNT_W'(DIGITS);
         end
      end else if (cmd.step) begin
         bcd_ff  <= {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_ff  <= {bin_ff[VALUE_W-2:0], 1'b0};
         step_ff <= step_ff + STEP_W'(1);
      end else if (cmd.shift) begin
         bcd_ff <= {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.out_load) begin
         char_ff <= char_in;
         last_ff <= cmd.out_last;
      end
   end

   assign status.is_hex    = hex_ff;
   assign status.is_neg    = neg_ff;
   assign status.top_zero  = (top_digit == '0);
   assign status.cnt_one   = (cnt_ff == CNT_W'(1));
   assign status.step_last = &step_ff;

   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== rtl/core/ifmt_ctrl.sv =====
// Controller of the integer-to-ASCII formatter: sequences conversion,
// leading-zero skipping, prefix and digit output, and owns rsp_valid.
// Depends on ifmt_pkg.
module ifmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ifmt_pkg::status_type status,
   output ifmt_pkg::cmd_type    cmd
);
   import ifmt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_PFX0,
      ST_PFX1,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // The output register can take a character when empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '{load: 1'b0, step: 1'b0, shift: 1'b0, out_load: 1'b0,
                   out_last: 1'b0, out_sel: SEL_DIGIT};
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.is_hex) begin
               state_in = ST_SKIP;
            end else begin
               cmd.step = 1'b1;
               if (status.step_last) begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            priority if (status.top_zero && !status.cnt_one) begin
               cmd.shift = 1'b1;
            end else if (status.is_hex) begin
               state_in = ST_PFX0;
            end else if (status.is_neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_PFX0: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_ZERO;
               state_in     = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_X;
               state_in     = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_MINUS;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_DIGIT;
               cmd.shift    = 1'b1;
               cmd.out_last = status.cnt_one;
               if (status.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/integer_to_ascii_formatter_top.sv =====
// Top level of the integer-to-ASCII formatter: joins controller and datapath.
// Depends on ifmt_pkg, ifmt_ctrl and ifmt_datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_value[63:0], req_mode[1:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_character[7:0], rsp_last
//
// Decimal requests are loaded, converted by shift-add-3 over the 64 value bits, then have
// their leading zeros suppressed before the optional sign and the digits are output.
// Hex requests skip conversion: load, the same zero skipping, then the prefix and characters.
// Reset idles the controller and empties the output register.
// The next request is taken while the final character still waits on rsp_stall.
module integer_to_ascii_formatter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ifmt_pkg::VALUE_W-1:0]  req_value,
   input  logic [ifmt_pkg::MODE_W-1:0]   req_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ifmt_pkg::CHAR_W-1:0]   rsp_character,
   output logic                          rsp_last
);
   import ifmt_pkg::*;

   cmd_type    cmd;
   status_type status;

   ifmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ifmt_datapath u_datapath (
      .clock         (clock),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .cmd           (cmd),
      .status        (status),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // A request being taken always makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting a request");

   // A non-final character can only be pending while its request is still in work.
   a_busy_mid_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("block idle while text incomplete");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear control state");

endmodule

// ===== tb/tb_integer_to_ascii_formatter_top.sv =====
// Self-checking testbench for integer_to_ascii_formatter_top.
// Depends on ifmt_pkg and the formatter RTL; predicts the text of every request
// and checks each character and its last flag against that prediction.
module tb_integer_to_ascii_formatter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ifmt_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 600;
   localparam int MAX_PRINTED  = 40;

   // The fourth mode code is not named by the package; it formats as unsigned decimal.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic [8*16-1:0] GLYPH_TABLE = "0123456789ABCDEF";

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [MODE_W-1:0]   req_mode = MODE_HEX;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;

   text_char_type expected_text[$];
   int  mismatches = 0;
   int  chars_checked = 0;
   int  numbers_done = 0;
   int  requests_sent = 0;
   int  mode_count[4] = '{0, 0, 0, 0};
   int  req_gap_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_pending = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  cycle_count = 0;

   integer_to_ascii_formatter_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Mostly short gaps, with an occasional long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         pick_gap = $urandom_range(12, 40);
      end else begin
         pick_gap = $urandom_range(1, 3);
      end
   endfunction

   // Spreads values over all text lengths, values near powers of ten and negated values.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] power;
      int                 exponent;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
            random_value = raw;
         end
         1: begin
            random_value = raw >> $urandom_range(0, 64);
         end
         2: begin
            power = 64'd1;
            exponent = $urandom_range(0, 19);
            repeat (exponent) power = power * 64'd10;
            random_value = power + 64'($urandom_range(0, 2)) - 64'd1;
         end
         default: begin
            random_value = -(raw >> $urandom_range(0, 64));
         end
      endcase
   endfunction

   // Appends the expected characters of one request, most significant first.
   function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                        input logic [MODE_W-1:0] mode);
      text_char_type      text[$];
      text_char_type      item;
      logic [VALUE_W-1:0] magnitude;
      logic [VALUE_W-1:0] radix;
      int                 digit;
      int                 prefix_len;
      magnitude = value;
      radix = 64'd10;
      item.last = 1'b0;
      if (mode == MODE_HEX) begin
         radix = 64'd16;
         item.code = ASCII_ZERO;
         text.push_back(item);
         item.code = ASCII_X;
         text.push_back(item);
      end else if (mode == MODE_SIGNED && value[VALUE_W-1]) begin
         item.code = ASCII_MINUS;
         text.push_back(item);
         // The most negative value wraps to its own magnitude here.
         magnitude = -value;
      end
      prefix_len = text.size();
      do begin
         digit = int'(magnitude % radix);
         item.code = GLYPH_TABLE[8*(15-digit) +: 8];
         text.insert(prefix_len, item);
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      text[text.size()-1].last = 1'b1;
      foreach (text[i]) expected_text.push_back(text[i]);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      // Keeps the log short when the design is badly broken.
      if (mismatches <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Offers one request, waits for it to be taken, then picks the gap before the next.
   task automatic send_request(input logic [VALUE_W-1:0] value,
                               input logic [MODE_W-1:0] mode);
      int gap;
      req_valid <= 1'b1;
      req_value <= value;
      req_mode  <= mode;
      do @(posedge clock); while (req_stall);
      predict_text(value, mode);
      requests_sent++;
      mode_count[mode]++;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Withdraws the offer first so the last request is not taken a second time.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      send_request(64'd0, MODE_HEX);
      send_request(64'd1, MODE_HEX);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX);
      send_request(64'h8000_0000_0000_0000, MODE_HEX);
      send_request(64'h0123_4567_89AB_CDEF, MODE_HEX);
      send_request(64'd0, MODE_UNSIGNED);
      send_request(64'd9, MODE_UNSIGNED);
      send_request(64'd10, MODE_UNSIGNED);
      send_request(64'd9_999_999_999_999_999_999, MODE_UNSIGNED);
      send_request(64'd10_000_000_000_000_000_000, MODE_UNSIGNED);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_UNSIGNED);
      send_request(64'd0, MODE_SIGNED);
      send_request(64'd7, MODE_SIGNED);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_SIGNED);
      send_request(-64'd10, MODE_SIGNED);
      send_request(64'h8000_0000_0000_0000, MODE_SIGNED);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, MODE_SIGNED);
      send_request(64'd0, MODE_SPARE);
      send_request(64'd12345, MODE_SPARE);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, MODE_SPARE);
      wait_until_drained();
   endtask

   task automatic test_random_with_gaps(input int count);
      req_gap_pct = 35;
      rsp_stall_pct = 25;
      repeat (count) send_request(random_value(), MODE_W'($urandom_range(0, 3)));
      wait_until_drained();
   endtask

   task automatic test_back_to_back(input int count);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      repeat (count) send_request(random_value(), MODE_W'($urandom_range(0, 3)));
      wait_until_drained();
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_output_backpressure(input int count);
      req_gap_pct = 0;
      rsp_stall_pct = 10;
      hold_pending = 1'b1;
      repeat (count) send_request(random_value(), MODE_W'($urandom_range(0, 3)));
      wait_until_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left = pick_gap() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("character %h with no request pending", rsp_character));
         end else begin
            want = expected_text.pop_front();
            if (rsp_character !== want.code) begin
               report_mismatch($sformatf("character %h, expected %h", rsp_character,
                                         want.code));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b on character %h",
                                         rsp_last, want.last, want.code));
            end
         end
         chars_checked++;
         if (rsp_last) numbers_done++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d characters outstanding", cycle_count,
               expected_text.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_with_gaps(130);
      test_back_to_back(40);
      test_output_backpressure(20);
      req_valid <= 1'b0;
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Formatted %0d requests (hex %0d, unsigned %0d, signed %0d, spare mode %0d),",
               requests_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("checked %0d characters over %0d numbers, %0d mismatches.",
               chars_checked, numbers_done, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_datapath.sv
rtl/core/ifmt_ctrl.sv
rtl/core/integer_to_ascii_formatter_top.sv
tb/tb_integer_to_ascii_formatter_top.sv
